// ----- design/ps2_mouse_packet_tracker_defines.svh -----
// Assertion macros shared by the checker files of the packet tracker.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PS2MT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PS2MT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ps2mt_pkg.sv -----
// Package of the PS/2 mouse packet tracker: widths, bit masks, register
// indexes, the packet slot type and the control struct of one axis. No dependencies.
package ps2mt_pkg;

	localparam int SIZE_BITS      = 12;
	localparam int COORD_BITS_DEF = 12;
	localparam int REG_IDX_BITS   = 1;
	localparam int DELTA_BITS     = 9;
	localparam int STEP_BITS      = 10;

	localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(640);
	localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(480);

	localparam logic [7:0] SYNC_BIT  = 8'h08;
	localparam logic [7:0] XSIGN_BIT = 8'h10;
	localparam logic [7:0] YSIGN_BIT = 8'h20;
	localparam logic [7:0] BTN_MASK  = 8'h07;

	localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

	typedef enum logic [1:0] {
		SLOT_HEADER,
		SLOT_XDELTA,
		SLOT_YDELTA
	} slot_t;

	typedef struct packed {
		logic cfg_we;
		logic step_en;
	} axis_ctrl_t;

endpackage

// ----- design/ps2mt_if.sv -----
// Handshake channels of the packet tracker: received bytes in, cursor reports out.
// Depends on nothing; the report width follows COORD_BITS.
interface ps2mt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_pos_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic [2:0]            button_bits;

	modport source (output valid, output cursor_x, output cursor_y, output button_bits,
		input ready);
	modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
		output ready);
endinterface

// ----- design/ps2mt_axis.sv -----
// One cursor axis: the size register, the position register and the clamped
// update. Depends on ps2mt_pkg.
module ps2mt_axis #(
	parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF,
	parameter logic [ps2mt_pkg::SIZE_BITS-1:0] RST_SIZE = ps2mt_pkg::WIDTH_RST
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ps2mt_pkg::axis_ctrl_t                 ctrl,
	input  logic [ps2mt_pkg::SIZE_BITS-1:0]       cfg_data,
	input  logic signed [ps2mt_pkg::STEP_BITS-1:0] step,
	output logic [COORD_BITS-1:0]                 pos_next
);
	import ps2mt_pkg::*;

	localparam int LW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
	localparam logic [LW-1:0] COORD_MAX_L = LW'(COORD_MAX);
	localparam logic [LW-1:0] RST_HALF = LW'(RST_SIZE / 2);
	localparam logic [COORD_BITS-1:0] RST_POS =
		(RST_HALF > COORD_MAX_L) ? COORD_MAX : COORD_BITS'(RST_HALF);

	logic [SIZE_BITS-1:0]         size_q;
	logic [COORD_BITS-1:0]        pos_q;
	logic [LW-1:0]                lim_raw;
	logic [LW-1:0]                centre_raw;
	logic [COORD_BITS-1:0]        hi_lim;
	logic [COORD_BITS-1:0]        centre;
	logic signed [COORD_BITS+1:0] sum;

	always_comb begin
		lim_raw    = LW'(size_q) - LW'(1);
		centre_raw = LW'(cfg_data >> 1);
		if (size_q == '0 || lim_raw > COORD_MAX_L) begin
			hi_lim = COORD_MAX;
		end else begin
			hi_lim = COORD_BITS'(lim_raw);
		end
		if (centre_raw > COORD_MAX_L) begin
			centre = COORD_MAX;
		end else begin
			centre = COORD_BITS'(centre_raw);
		end
	end

	// The sum is two bits wider than the position, so a step of either sign
	// cannot wrap before it is clamped.
	always_comb begin
		sum = $signed({2'b00, pos_q}) + (COORD_BITS+2)'(step);
		if (sum[COORD_BITS+1]) begin
			pos_next = '0;
		end else if (sum[COORD_BITS:0] > {1'b0, hi_lim}) begin
			pos_next = hi_lim;
		end else begin
			pos_next = sum[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= RST_SIZE;
			pos_q  <= RST_POS;
		end else if (ctrl.cfg_we) begin
			size_q <= cfg_data;
			pos_q  <= centre;
		end else if (ctrl.step_en) begin
			pos_q  <= pos_next;
		end
	end

endmodule

// ----- design/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: byte input register, packet
// slot sequencer, two axis units and the report register. Depends on
// ps2mt_pkg, ps2mt_if and ps2mt_axis.
//
//   Channel   Direction   Carries                              Accepted when
//   rx        in          rx_byte                              rx.valid && rx.ready
//   cursor    out         cursor_x, cursor_y, button_bits      cursor.valid && cursor.ready
//   cfg       in          cfg_index, cfg_data (write only)     cfg_we
//
// One byte is taken every cycle unless a pending report stalls. A byte is first held in the
// input register and is decoded from there, so the report register is loaded from the input
// register when the request carrying the Y delta moves on out of it.
// Reset clears the input and report valid flags, returns the sequencer to
// waiting for a header and loads the sizes 640 by 480 with the cursor at
// their center. No clearing pass is needed.
// A report that is not taken holds the report register; the byte behind it
// waits in the input register, and only then does rx.ready drop.
module ps2_mouse_packet_tracker #(
	parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ps2mt_byte_if.sink                          rx,
	ps2mt_pos_if.source                         cursor,
	input  logic                                cfg_we,
	input  logic [ps2mt_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  logic [ps2mt_pkg::SIZE_BITS-1:0]     cfg_data
);
	import ps2mt_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Packet sequencer state and the bytes kept from earlier in the packet.
	slot_t      slot_q;
	slot_t      slot_next;
	logic [7:0] header_q;
	logic [7:0] xbyte_q;

	// Report register.
	logic                  res_valid_q;
	logic [COORD_BITS-1:0] res_x_q;
	logic [COORD_BITS-1:0] res_y_q;
	logic [2:0]            res_btn_q;

	logic advance;
	logic take_header;
	logic take_x;
	logic emit;

	logic signed [DELTA_BITS-1:0] dx;
	logic signed [DELTA_BITS-1:0] dy;
	logic signed [STEP_BITS-1:0]  step_x;
	logic signed [STEP_BITS-1:0]  step_y;

	axis_ctrl_t            ctrl_x;
	axis_ctrl_t            ctrl_y;
	logic [COORD_BITS-1:0] x_next;
	logic [COORD_BITS-1:0] y_next;

	// The held byte moves on whenever the report register is free or being
	// emptied in this cycle; a new byte can then enter behind it.
	assign advance  = valid_s1 && (!res_valid_q || cursor.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Next slot. While waiting for a header, bytes without the sync bit are dropped.
	always_comb begin
		slot_next = slot_q;
		case (slot_q)
			SLOT_HEADER: begin
				if (advance && ((byte_s1 & SYNC_BIT) != '0)) begin
					slot_next = SLOT_XDELTA;
				end
			end
			SLOT_XDELTA: begin
				if (advance) begin
					slot_next = SLOT_YDELTA;
				end
			end
			SLOT_YDELTA: begin
				if (advance) begin
					slot_next = SLOT_HEADER;
				end
			end
			default: begin
				slot_next = SLOT_HEADER;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		take_header = 1'b0;
		take_x      = 1'b0;
		emit        = 1'b0;
		case (slot_q)
			SLOT_HEADER: take_header = advance && ((byte_s1 & SYNC_BIT) != '0);
			SLOT_XDELTA: take_x      = advance;
			SLOT_YDELTA: emit        = advance;
			default: begin
				take_header = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_HEADER;
		end else begin
			slot_q <= slot_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take_header) begin
			header_q <= byte_s1;
		end
		if (take_x) begin
			xbyte_q <= byte_s1;
		end
	end

	// The deltas are nine-bit two's complement with their sign bits in the
	// header. Y counts upward on the mouse and downward on the screen, so it
	// is negated; the ten-bit step holds the negation of the most negative delta.
	assign dx     = $signed({(header_q & XSIGN_BIT) != '0, xbyte_q});
	assign dy     = $signed({(header_q & YSIGN_BIT) != '0, byte_s1});
	assign step_x = STEP_BITS'(dx);
	assign step_y = -(STEP_BITS'(dy));

	// A size write recenters its axis; user must keep no byte in flight (not enforced).
	always_comb begin
		ctrl_x.cfg_we  = cfg_we && (cfg_index == REG_SCREEN_WIDTH);
		ctrl_x.step_en = emit;
		ctrl_y.cfg_we  = cfg_we && (cfg_index == REG_SCREEN_HEIGHT);
		ctrl_y.step_en = emit;
	end

	ps2mt_axis #(
		.COORD_BITS (COORD_BITS),
		.RST_SIZE   (WIDTH_RST)
	) u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_x),
		.cfg_data (cfg_data),
		.step     (step_x),
		.pos_next (x_next)
	);

	ps2mt_axis #(
		.COORD_BITS (COORD_BITS),
		.RST_SIZE   (HEIGHT_RST)
	) u_axis_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_y),
		.cfg_data (cfg_data),
		.step     (step_y),
		.pos_next (y_next)
	);

	// Report register: filled by the last byte of a packet, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (cursor.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_x_q   <= x_next;
			res_y_q   <= y_next;
			res_btn_q <= 3'(header_q & BTN_MASK);
		end
	end

	assign cursor.valid       = res_valid_q;
	assign cursor.cursor_x    = res_x_q;
	assign cursor.cursor_y    = res_y_q;
	assign cursor.button_bits = res_btn_q;

endmodule

// ----- design/ps2mt_checker.sv -----
// Port-level checks of the packet tracker and the bind that attaches them.
// Depends on ps2_mouse_packet_tracker_defines.svh.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rx_valid,
	input logic                  rx_ready,
	input logic                  cursor_valid,
	input logic                  cursor_ready,
	input logic [COORD_BITS-1:0] cursor_x,
	input logic [COORD_BITS-1:0] cursor_y,
	input logic [2:0]            button_bits
);

	// A stalled report stays and keeps its payload.
	`PS2MT_ASSERT_NEXT(a_report_held, cursor_valid && !cursor_ready,
		cursor_valid && $stable(cursor_x) && $stable(cursor_y) && $stable(button_bits),
		"report changed while stalled")

	// A new report follows an accepted byte, which passes through the input register and then the report register.
	`PS2MT_ASSERT_NOW(a_report_latency, $rose(cursor_valid),
		$past(rx_valid && rx_ready, 2), "report without a byte two cycles before")

	// With the report register empty nothing can hold back the input.
	`PS2MT_ASSERT_NOW(a_ready_when_empty, !cursor_valid, rx_ready,
		"input stalled while no report is pending")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker #(
	.COORD_BITS (COORD_BITS)
) u_ps2mt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.cursor_valid (cursor.valid),
	.cursor_ready (cursor.ready),
	.cursor_x     (cursor.cursor_x),
	.cursor_y     (cursor.cursor_y),
	.button_bits  (cursor.button_bits)
);
